// ===== src/gupa_pkg.sv =====
// ============================================================================
// gupa_pkg : shared types and constants of the unit pool allocator
// Opcodes, status codes and field widths.
// ============================================================================
`default_nettype none
package gupa_pkg;
    localparam int MAX_BLOCKS = 8;
    localparam int UNIT_CAP   = 256;
    localparam int SLOT_W     = $clog2(MAX_BLOCKS);
    localparam int UNIT_W     = $clog2(UNIT_CAP);
    localparam int ADDR_W     = 11;
    localparam int CNT_W      = 9;
    localparam int BLK_W      = 4;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INIT  = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BADADDR = 2'd1;
    localparam logic [1:0] ST_OOM     = 2'd2;

    localparam logic REG_UNIT_COUNT = 1'b0;
    localparam logic REG_MIN_BLOCKS = 1'b1;
endpackage
`default_nettype wire

// ===== src/growable_unit_pool_allocator_unit.sv =====
// ============================================================================
// growable_unit_pool_allocator_unit : pool of fixed-size units in blocks
// Allocates and frees unit handles over up to eight blocks with LIFO lists.
// ============================================================================
// Steps: init builds min_blocks blocks in turn; free pushes the unit, and when
// a wholly free block is released the chain compacts; allocate scans the chain
// entries in turn (up to 8), building a new block when none has a free unit.
// The unused opcode goes straight to the result. A taken unit waits for its link read.
// One item at a time; input ready returns the cycle after the result transfers.
// Reset (synchronous, active low) clears blocks and chain; link memory is kept.
`default_nettype none
module growable_unit_pool_allocator_unit
    import gupa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [8:0]        i_cfg_data,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [1:0]        i_opcode,
    input  wire logic [ADDR_W-1:0] i_address,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [1:0]             o_status,
    output logic [ADDR_W-1:0]      o_granted_address,
    output logic [BLK_W-1:0]       o_block_count
);
    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_SCAN, S_NEWBLK, S_TAKE, S_TAKE2,
        S_FREE, S_COMPACT, S_DONE
    } t_state;

    // Link memory: one entry per unit, undefined until written.
    logic [UNIT_W-1:0] r_link [MAX_BLOCKS*UNIT_CAP];
    logic [UNIT_W-1:0] r_link_rd;

    logic [CNT_W-1:0]  r_unit_count;
    logic [BLK_W-1:0]  r_min_blocks;

    logic [UNIT_W-1:0] r_free_head [MAX_BLOCKS];
    logic [CNT_W-1:0]  r_mark      [MAX_BLOCKS];
    logic [CNT_W-1:0]  r_free      [MAX_BLOCKS];
    logic [CNT_W-1:0]  r_units     [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] r_active;
    logic [SLOT_W-1:0] r_chain     [MAX_BLOCKS];
    logic [BLK_W-1:0]  r_nblk;

    t_state            r_state;
    logic [ADDR_W-1:0] r_addr;
    logic [BLK_W-1:0]  r_k;      // chain scan / build / compact index
    logic [BLK_W-1:0]  r_j;      // compact write index
    logic [SLOT_W-1:0] r_slot;

    logic [CNT_W-1:0]  eff_units;
    logic [BLK_W-1:0]  eff_min;
    logic [SLOT_W-1:0] idle_slot;
    logic              idle_any;
    logic [SLOT_W-1:0] a_slot;
    logic [UNIT_W-1:0] a_unit;
    logic [SLOT_W-1:0] cur_slot;

    always_comb begin
        eff_units = r_unit_count;
        if (r_unit_count == '0) eff_units = CNT_W'(1);
        if (r_unit_count > CNT_W'(UNIT_CAP)) eff_units = CNT_W'(UNIT_CAP);
        eff_min = (r_min_blocks > BLK_W'(MAX_BLOCKS)) ? BLK_W'(MAX_BLOCKS) : r_min_blocks;
        idle_slot = '0;
        idle_any  = 1'b0;
        for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                idle_slot = SLOT_W'(i);
                idle_any  = 1'b1;
            end
        end
        a_slot   = r_addr[UNIT_W +: SLOT_W];
        a_unit   = r_addr[UNIT_W-1:0];
        cur_slot = r_chain[r_k[SLOT_W-1:0]];
    end

    assign o_ready = (r_state == S_IDLE) && !o_valid;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_count   <= CNT_W'(UNIT_CAP);
            r_min_blocks   <= BLK_W'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_UNIT_COUNT) r_unit_count <= i_cfg_data;
            else r_min_blocks <= i_cfg_data[BLK_W-1:0];
        end
    end

    // Link memory: read the head's successor, write on free
    always_ff @(posedge i_clk) begin
        r_link_rd <= r_link[{r_slot, r_free_head[r_slot]}];
        if (r_state == S_FREE && r_active[a_slot]
            && {1'b0, a_unit} < r_units[a_slot] && r_free[a_slot] < r_units[a_slot]) begin
            r_link[{a_slot, a_unit}] <= r_free_head[a_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            o_valid  <= 1'b0;
            r_active <= '0;
            r_nblk   <= '0;
            for (int i = 0; i < MAX_BLOCKS; i++) begin
                r_chain[i]     <= '0;
                r_free[i]      <= '0;
                r_mark[i]      <= '0;
                r_units[i]     <= '0;
                r_free_head[i] <= '0;
            end
        end else begin
            if (o_valid && i_ready) o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_addr <= i_address;
                        r_k    <= '0;
                        r_j    <= '0;
                        o_status          <= ST_OK;
                        o_granted_address <= '0;
                        unique case (t_opcode'(i_opcode))
                            OP_INIT: begin
                                r_active <= '0;
                                r_nblk   <= '0;
                                for (int i = 0; i < MAX_BLOCKS; i++) r_chain[i] <= '0;
                                r_state <= S_INIT;
                            end
                            OP_ALLOC: r_state <= S_SCAN;
                            OP_FREE:  r_state <= S_FREE;
                            default:  r_state <= S_DONE;
                        endcase
                    end
                end
                S_INIT: begin
                    // build one block per cycle, pushing each at the chain head
                    if (r_k >= eff_min) begin
                        r_state <= S_DONE;
                    end else begin
                        r_active[r_k[SLOT_W-1:0]]    <= 1'b1;
                        r_units[r_k[SLOT_W-1:0]]     <= eff_units;
                        r_free[r_k[SLOT_W-1:0]]      <= eff_units;
                        r_mark[r_k[SLOT_W-1:0]]      <= '0;
                        r_free_head[r_k[SLOT_W-1:0]] <= '0;
                        r_chain[0] <= r_k[SLOT_W-1:0];
                        for (int i = 1; i < MAX_BLOCKS; i++) r_chain[i] <= r_chain[i-1];
                        r_nblk <= r_nblk + 1'b1;
                        r_k    <= r_k + 1'b1;
                    end
                end
                S_SCAN: begin
                    // one chain entry per cycle
                    if (r_k >= r_nblk) begin
                        r_state <= S_NEWBLK;
                    end else if (r_free[cur_slot] != '0) begin
                        r_slot  <= cur_slot;
                        r_state <= S_TAKE;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_NEWBLK: begin
                    if (idle_any && r_nblk < BLK_W'(MAX_BLOCKS)) begin
                        r_active[idle_slot]    <= 1'b1;
                        r_units[idle_slot]     <= eff_units;
                        r_free[idle_slot]      <= eff_units;
                        r_mark[idle_slot]      <= '0;
                        r_free_head[idle_slot] <= '0;
                        r_chain[0] <= idle_slot;
                        for (int i = 1; i < MAX_BLOCKS; i++) r_chain[i] <= r_chain[i-1];
                        r_nblk  <= r_nblk + 1'b1;
                        r_slot  <= idle_slot;
                        r_state <= S_TAKE;
                    end else begin
                        o_status <= ST_OOM;
                        r_state  <= S_DONE;
                    end
                end
                S_TAKE: begin
                    // wait here for the link read of this slot's head
                    r_state <= S_TAKE2;
                end
                S_TAKE2: begin
                    if (r_free[r_slot] > r_units[r_slot] - r_mark[r_slot]) begin
                        o_granted_address <= {r_slot, r_free_head[r_slot]};
                        r_free_head[r_slot] <= r_link_rd;
                    end else begin
                        o_granted_address <= {r_slot, r_mark[r_slot][UNIT_W-1:0]};
                        r_mark[r_slot] <= r_mark[r_slot] + 1'b1;
                    end
                    r_free[r_slot] <= r_free[r_slot] - 1'b1;
                    r_state <= S_DONE;
                end
                S_FREE: begin
                    if (!r_active[a_slot] || {1'b0, a_unit} >= r_units[a_slot]) begin
                        o_status <= ST_BADADDR;
                        r_state  <= S_DONE;
                    end else if (r_free[a_slot] < r_units[a_slot]) begin
                        r_free_head[a_slot] <= a_unit;
                        r_free[a_slot]      <= r_free[a_slot] + 1'b1;
                        if (r_free[a_slot] + 1'b1 == r_units[a_slot] && r_nblk > eff_min) begin
                            r_active[a_slot] <= 1'b0;
                            r_slot  <= a_slot;
                            r_state <= S_COMPACT;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_COMPACT: begin
                    // drop the released slot from the chain, one entry a cycle
                    if (r_k >= r_nblk) begin
                        for (int i = 0; i < MAX_BLOCKS; i++)
                            if (BLK_W'(i) >= r_j) r_chain[i] <= '0;
                        r_nblk  <= r_j;
                        r_state <= S_DONE;
                    end else begin
                        if (cur_slot != r_slot) begin
                            r_chain[r_j[SLOT_W-1:0]] <= cur_slot;
                            r_j <= r_j + 1'b1;
                        end
                        r_k <= r_k + 1'b1;
                    end
                end
                S_DONE: begin
                    o_block_count <= r_nblk;
                    o_valid       <= 1'b1;
                    r_state       <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== src/gupa_checker.sv =====
// ============================================================================
// gupa_checker : port-level checks of the unit pool allocator
// Watches handshakes and result fields over time.
// ============================================================================
`default_nettype none
module gupa_checker
    import gupa_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_ready,
    input wire logic              o_valid,
    input wire logic              i_ready,
    input wire logic [1:0]        o_status,
    input wire logic [ADDR_W-1:0] o_granted_address,
    input wire logic [BLK_W-1:0]  o_block_count
);
    a_no_accept_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready while result pending");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_granted_address)
        && $stable(o_status)) else $error("result changed while stalled");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_block_count <= BLK_W'(MAX_BLOCKS)) else $error("block count");
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_granted_address == '0)
        else $error("grant on error");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= ST_OOM) else $error("bad status");
endmodule

bind growable_unit_pool_allocator_unit gupa_checker u_gupa_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_status(o_status),
    .o_granted_address(o_granted_address), .o_block_count(o_block_count)
);
`default_nettype wire
